@@ hdl/bdcl_pkg.sv @@
// ----------------------------------------------------------------------------
// bdcl_pkg
// Shared widths, register codes and structs of the button debouncer with
// click and long-press detection.
// ----------------------------------------------------------------------------
`default_nettype none

package bdcl_pkg;

    // fixed widths of the external fields
    localparam int MASK_W  = 8;   // one bit per button on every port
    localparam int TICK_W  = 8;
    localparam int TIME_W  = 16;
    localparam int CNT_W   = 4;   // debounce count
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TICK_MS          = 2'd0,
        REG_CLICK_MS         = 2'd1,
        REG_LONG_PRESS_MS    = 2'd2,
        REG_ACTIVE_HIGH_MASK = 2'd3
    } t_reg_idx;

    // timing settings shared by every lane
    typedef struct packed {
        logic [TICK_W-1:0] tick_ms;
        logic [TIME_W-1:0] click_ms;
        logic [TIME_W-1:0] long_press_ms;
    } t_cfg;

    // events found by one lane in one tick
    typedef struct packed {
        logic press;
        logic click;
        logic release_ev;
        logic long_press;
    } t_lane_ev;

    // one output word
    typedef struct packed {
        logic [MASK_W-1:0] press;
        logic [MASK_W-1:0] click;
        logic [MASK_W-1:0] release_ev;
        logic [MASK_W-1:0] long_press;
    } t_events;

endpackage

`default_nettype wire

@@ hdl/bdcl_lane.sv @@
// ----------------------------------------------------------------------------
// bdcl_lane
// One button: hold timer, polarity correction, debounce and event decode.
// State advances once per accepted tick, events come out combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module bdcl_lane #(
    parameter int DEBOUNCE_TICKS = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic               i_raw,
    input  wire logic               i_active_high,
    input  var  bdcl_pkg::t_cfg     i_cfg,
    output      bdcl_pkg::t_lane_ev o_ev
);
    import bdcl_pkg::*;

    logic              r_level;
    logic [CNT_W-1:0]  r_count;
    logic              r_idle;
    logic [TIME_W-1:0] r_hold;
    logic              r_active;

    logic              n_level;
    logic [CNT_W-1:0]  n_count;
    logic              n_idle;
    logic [TIME_W-1:0] n_hold;
    logic              n_active;

    logic              pressed;
    logic [TIME_W:0]   hold_sum;
    logic [TIME_W-1:0] hold_sat;
    logic [TIME_W-1:0] hold_1;
    logic              active_1;
    logic              long_hit;
    logic [CNT_W-1:0]  count_inc;

    // hold timer advances first, saturating
    assign hold_sum = {1'b0, r_hold} + {{(TIME_W + 1 - TICK_W){1'b0}}, i_cfg.tick_ms};
    assign hold_sat = hold_sum[TIME_W] ? {TIME_W{1'b1}} : hold_sum[TIME_W-1:0];
    assign hold_1   = r_active ? hold_sat : r_hold;
    assign long_hit = r_active && (hold_sat > i_cfg.long_press_ms);
    assign active_1 = r_active && !long_hit;

    // pressed when raw level matches the active polarity
    assign pressed   = ~(i_raw ^ i_active_high);
    assign count_inc = r_count + CNT_W'(1);

    // debounce and event decode
    always_comb begin
        n_level = r_level;
        n_count = r_count;
        n_idle  = r_idle;
        n_hold  = hold_1;
        n_active = active_1;
        o_ev = '0;
        o_ev.long_press = long_hit;
        if (pressed != r_level) begin
            n_level = pressed;
            n_count = '0;
            n_idle  = 1'b0;
        end else if (!r_idle) begin
            n_count = count_inc;
            if (count_inc >= CNT_W'(DEBOUNCE_TICKS)) begin
                n_idle = 1'b1;
                if (pressed) begin
                    o_ev.press = 1'b1;
                    n_hold     = '0;
                    n_active   = 1'b1;
                end else begin
                    if (active_1) begin
                        if (hold_1 < i_cfg.click_ms) begin
                            o_ev.click = 1'b1;
                        end else if (hold_1 <= i_cfg.long_press_ms) begin
                            o_ev.release_ev = 1'b1;
                        end
                    end
                    n_active = 1'b0;
                end
            end
        end
    end

    // lane state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= 1'b0;
            r_count  <= '0;
            r_idle   <= 1'b1;
            r_hold   <= '0;
            r_active <= 1'b0;
        end else if (i_accept) begin
            r_level  <= n_level;
            r_count  <= n_count;
            r_idle   <= n_idle;
            r_hold   <= n_hold;
            r_active <= n_active;
        end
    end

endmodule

`default_nettype wire

@@ hdl/bdcl_merge.sv @@
// ----------------------------------------------------------------------------
// bdcl_merge
// Packs the lane events into per-button masks and holds them in an output
// register backed by a skid register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdcl_merge #(
    parameter int LANES = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  var  bdcl_pkg::t_lane_ev [LANES-1:0] i_lane_ev,
    output      logic                          o_full,
    output      logic                          o_valid,
    input  wire logic                          i_stall,
    output      bdcl_pkg::t_events             o_events
);
    import bdcl_pkg::*;

    t_events merged;
    t_events r_out;
    t_events r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    n_out_valid;
    logic    n_skid_valid;
    logic    take;
    logic    load_out;
    logic    load_skid;
    logic    move_skid;

    // lane events into masks, missing lanes read zero
    always_comb begin
        merged = '0;
        for (int i = 0; i < LANES; i++) begin
            merged.press[i]      = i_lane_ev[i].press;
            merged.click[i]      = i_lane_ev[i].click;
            merged.release_ev[i] = i_lane_ev[i].release_ev;
            merged.long_press[i] = i_lane_ev[i].long_press;
        end
    end

    // output and skid control
    assign take = r_out_valid && !i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        load_out     = 1'b0;
        load_skid    = 1'b0;
        move_skid    = 1'b0;
        if (take) begin
            if (r_skid_valid) begin
                move_skid    = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (i_accept) begin
            if (!r_out_valid || (take && !r_skid_valid)) begin
                load_out    = 1'b1;
                n_out_valid = 1'b1;
            end else begin
                load_skid    = 1'b1;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload words
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= merged;
        end else if (move_skid) begin
            r_out <= r_skid;
        end
        if (load_skid) begin
            r_skid <= merged;
        end
    end

    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_events = r_out;

endmodule

`default_nettype wire

@@ hdl/button_debounce_click_longpress.sv @@
// Each event word is registered at the output, or in the skid word while the output stalls.
// Throughput: one tick per cycle while o_stall is low; the lanes update in the accept cycle.
// An output stall lets one more tick into the skid word, then stalls the input till it drains.
// Reset (synchronous, active low) clears all lane state, empties the output
// stage and restores the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// button_debounce_click_longpress
// Per-button debounce with press, click, release and long-press events.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_click_longpress #(
    parameter int BUTTONS        = 8,
    parameter int DEBOUNCE_TICKS = 4
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // tick input
    input  wire logic                                i_valid,
    output      logic                                o_stall,
    input  wire logic [bdcl_pkg::MASK_W-1:0]         i_raw_levels,
    // event output
    output      logic                                o_valid,
    input  wire logic                                i_stall,
    output      logic [bdcl_pkg::MASK_W-1:0]         o_press_events,
    output      logic [bdcl_pkg::MASK_W-1:0]         o_click_events,
    output      logic [bdcl_pkg::MASK_W-1:0]         o_release_events,
    output      logic [bdcl_pkg::MASK_W-1:0]         o_long_press_events,
    // configuration writes
    input  wire logic                                i_cfg_valid,
    output      logic                                o_cfg_ready,
    input  wire logic [bdcl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [bdcl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bdcl_pkg::*;

    // only the buttons that have a port bit get a lane
    localparam int LANES = (BUTTONS < MASK_W) ? BUTTONS : MASK_W;

    t_cfg              r_cfg;
    logic [MASK_W-1:0] r_active_high;
    logic              accept;
    logic              full;
    t_lane_ev [LANES-1:0] lane_ev;
    t_events           events;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_ms       <= TICK_W'(5);
            r_cfg.click_ms      <= TIME_W'(300);
            r_cfg.long_press_ms <= TIME_W'(1000);
            r_active_high       <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_TICK_MS:          r_cfg.tick_ms       <= i_cfg_data[TICK_W-1:0];
                REG_CLICK_MS:         r_cfg.click_ms      <= i_cfg_data[TIME_W-1:0];
                REG_LONG_PRESS_MS:    r_cfg.long_press_ms <= i_cfg_data[TIME_W-1:0];
                REG_ACTIVE_HIGH_MASK: r_active_high       <= i_cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // tick handshake
    assign accept  = i_valid && !full;
    assign o_stall = full;

    // button lanes
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        bdcl_lane #(
            .DEBOUNCE_TICKS (DEBOUNCE_TICKS)
        ) u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_accept      (accept),
            .i_raw         (i_raw_levels[g]),
            .i_active_high (r_active_high[g]),
            .i_cfg         (r_cfg),
            .o_ev          (lane_ev[g])
        );
    end

    // merge and output stage
    bdcl_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_lane_ev (lane_ev),
        .o_full    (full),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_events  (events)
    );

    assign o_press_events      = events.press;
    assign o_click_events      = events.click;
    assign o_release_events    = events.release_ev;
    assign o_long_press_events = events.long_press;

endmodule

`default_nettype wire

@@ hdl/bdcl_checker.sv @@
// ----------------------------------------------------------------------------
// bdcl_checker
// Port-level checks of the debouncer's output stage and event words.
// ----------------------------------------------------------------------------
`default_nettype none

module bdcl_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_valid,
    input wire logic                            o_stall,
    input wire logic                            o_valid,
    input wire logic                            i_stall,
    input wire logic [bdcl_pkg::MASK_W-1:0]     o_press_events,
    input wire logic [bdcl_pkg::MASK_W-1:0]     o_click_events,
    input wire logic [bdcl_pkg::MASK_W-1:0]     o_release_events,
    input wire logic [bdcl_pkg::MASK_W-1:0]     o_long_press_events
);

    // input is held back only while a word waits at the output
    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no output word pending");

    // after a taken tick an output word is pending in the next cycle
    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("accepted tick produced no output word");

    // a tick taken while the output is blocked fills the skid word
    a_skid_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && o_valid && i_stall) |=> o_stall)
        else $error("output blocked but input not stalled after accept");

    // one lane gives at most one of press, click and release per tick
    a_events_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (((o_press_events & o_click_events) == '0)
                  && ((o_press_events & o_release_events) == '0)
                  && ((o_click_events & o_release_events) == '0)))
        else $error("conflicting events for one button");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_press_events)
            && $stable(o_click_events) && $stable(o_release_events)
            && $stable(o_long_press_events)))
        else $error("stalled output word changed");

endmodule

bind button_debounce_click_longpress bdcl_checker u_bdcl_checker (.*);

`default_nettype wire
